### rtl/core/abs_pkg.sv
// shared types and constants for the alternating-bit sender
// no dependencies; imported by every module of the block
`default_nettype none

package abs_pkg;

  // width of the additive checksum
  localparam int CHECK_W = 13;

  // timeout register value after reset
  localparam logic [15:0] TIMEOUT_RESET = 16'd15;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_MSG  = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_TICK = 2'd2
  } abs_kind_t;

  // send command from the front to the back
  typedef struct packed {
    logic resend;
    logic seq;
    logic ovf;
  } abs_cmd_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_META,
    BK_READ,
    BK_LOAD
  } abs_bk_state_t;

endpackage

`default_nettype wire

### rtl/core/abs_cmd_fifo.sv
// two-entry command queue between the front and the back
// depends on abs_pkg for the command type
`default_nettype none

module abs_cmd_fifo
  import abs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire abs_cmd_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          empty,
  output abs_cmd_t      head_data
);

  abs_cmd_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign head_data = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

### rtl/core/abs_front.sv
// front end: accepts items, assembles messages, checks acks, runs the timer
// depends on abs_pkg; issues send commands and message memory writes
`default_nettype none

module abs_front
  import abs_pkg::*;
#(
  parameter int MSG_BYTES  = 20,
  parameter int QUEUE_MSGS = 16,
  localparam int LW = $clog2(MSG_BYTES + 1),
  localparam int SW = (QUEUE_MSGS > 1) ? $clog2(QUEUE_MSGS) : 1,
  localparam int AW = (QUEUE_MSGS * MSG_BYTES > 1) ? $clog2(QUEUE_MSGS * MSG_BYTES) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          kind,
  input  wire logic [7:0]          data_byte,
  input  wire logic                byte_last,
  input  wire logic                ack_seq_field,
  input  wire logic                ack_number,
  input  wire logic [CHECK_W-1:0]  ack_check_value,
  input  wire logic                cfg_valid,
  input  wire logic [15:0]         cfg_data,
  output logic                     cmd_push,
  output abs_cmd_t                 cmd,
  input  wire logic                cmd_full,
  input  wire logic                back_quiet,
  output logic                     qwr_en,
  output logic [AW-1:0]            qwr_addr,
  output logic [7:0]               qwr_data,
  output logic                     mwr_en,
  output logic [SW-1:0]            mwr_slot,
  output logic [LW-1:0]            mwr_len,
  output logic [CHECK_W-1:0]       mwr_sum
);

  localparam int KW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int CW = $clog2(QUEUE_MSGS + 1);

  // registers
  logic [15:0]        timeout_ticks, timeout_ticks_next;
  logic               seq, seq_next;
  logic               awaiting, awaiting_next;
  logic [15:0]        timer, timer_next;
  logic [SW-1:0]      tail, tail_next;
  logic [AW-1:0]      tail_base, tail_base_next;
  logic [CW-1:0]      count, count_next;
  logic [KW-1:0]      fill, fill_next;
  logic               dropping, dropping_next;
  logic [CHECK_W-1:0] msg_sum, msg_sum_next;
  logic [CHECK_W-1:0] ack_sum, ack_sum_next;
  logic               overflow, overflow_next;

  // combinational helpers
  abs_kind_t          kind_e;
  logic               accept;
  logic               first;
  logic               drop_now;
  logic               msg_end;
  logic [CHECK_W-1:0] sum_acc;
  logic [CHECK_W-1:0] ack_total;
  logic [CHECK_W-1:0] ack_calc;
  logic [15:0]        reload;
  logic [CW-1:0]      cnt_mid;
  logic               seq_mid;
  logic               ovf_mid;
  logic               send_fresh;
  logic               send_resend;

  assign kind_e    = abs_kind_t'(kind);
  assign in_ready  = !cmd_full && !(kind_e == KIND_MSG && !back_quiet);
  assign accept    = in_valid && in_ready;
  assign first     = (fill == '0);
  assign drop_now  = first ? (count >= CW'(QUEUE_MSGS)) : dropping;
  assign msg_end   = byte_last || (fill == KW'(MSG_BYTES - 1));
  assign sum_acc   = (first ? '0 : msg_sum) + CHECK_W'(data_byte);
  assign ack_total = ack_sum + CHECK_W'(data_byte);
  assign ack_calc  = ack_total + CHECK_W'(ack_seq_field) + CHECK_W'(ack_number);
  assign reload    = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;

  // message memory write ports
  assign qwr_addr = tail_base + AW'(fill);
  assign qwr_data = data_byte;
  assign mwr_slot = tail;
  assign mwr_len  = LW'(fill) + LW'(1);
  assign mwr_sum  = sum_acc;

  // item handling
  always_comb begin
    timeout_ticks_next = cfg_valid ? cfg_data : timeout_ticks;
    seq_next       = seq;
    awaiting_next  = awaiting;
    timer_next     = timer;
    tail_next      = tail;
    tail_base_next = tail_base;
    count_next     = count;
    fill_next      = fill;
    dropping_next  = dropping;
    msg_sum_next   = msg_sum;
    ack_sum_next   = ack_sum;
    overflow_next  = overflow;
    qwr_en         = 1'b0;
    mwr_en         = 1'b0;
    cnt_mid        = count;
    seq_mid        = seq;
    ovf_mid        = overflow;
    send_fresh     = 1'b0;
    send_resend    = 1'b0;

    if (accept) begin
      case (kind_e)
        KIND_MSG: begin
          ovf_mid       = overflow | (first & drop_now);
          overflow_next = ovf_mid;
          qwr_en        = !drop_now;
          msg_sum_next  = sum_acc;
          if (msg_end) begin
            if (!drop_now) begin
              mwr_en = 1'b1;
              if (tail == SW'(QUEUE_MSGS - 1)) begin
                tail_next      = '0;
                tail_base_next = '0;
              end else begin
                tail_next      = tail + SW'(1);
                tail_base_next = tail_base + AW'(MSG_BYTES);
              end
              cnt_mid = count + CW'(1);
            end
            fill_next     = '0;
            dropping_next = 1'b0;
            send_fresh    = !awaiting && (cnt_mid != '0);
          end else begin
            fill_next     = fill + KW'(1);
            dropping_next = drop_now;
          end
        end
        KIND_ACK: begin
          if (!byte_last) begin
            ack_sum_next = ack_total;
          end else begin
            ack_sum_next = '0;
            if (awaiting && ack_check_value == ack_calc && ack_number == seq) begin
              timer_next    = 16'd0;
              seq_mid       = ~seq;
              seq_next      = seq_mid;
              awaiting_next = 1'b0;
              send_fresh    = (count != '0);
            end
          end
        end
        KIND_TICK: begin
          if (awaiting) begin
            if (timer > 16'd1) begin
              timer_next = timer - 16'd1;
            end else begin
              timer_next  = reload;
              send_resend = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    count_next = cnt_mid;
    // hand the head message to the back end
    if (send_fresh) begin
      count_next    = cnt_mid - CW'(1);
      awaiting_next = 1'b1;
      timer_next    = reload;
    end

    cmd_push   = send_fresh || send_resend;
    cmd.resend = send_resend;
    cmd.seq    = seq_mid;
    cmd.ovf    = ovf_mid;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      seq           <= 1'b0;
      awaiting      <= 1'b0;
      timer         <= 16'd0;
      tail          <= '0;
      tail_base     <= '0;
      count         <= '0;
      fill          <= '0;
      dropping      <= 1'b0;
      msg_sum       <= '0;
      ack_sum       <= '0;
      overflow      <= 1'b0;
    end else begin
      timeout_ticks <= timeout_ticks_next;
      seq           <= seq_next;
      awaiting      <= awaiting_next;
      timer         <= timer_next;
      tail          <= tail_next;
      tail_base     <= tail_base_next;
      count         <= count_next;
      fill          <= fill_next;
      dropping      <= dropping_next;
      msg_sum       <= msg_sum_next;
      ack_sum       <= ack_sum_next;
      overflow      <= overflow_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/abs_back.sv
// back end: holds the message queue and the kept packet, streams out packets
// depends on abs_pkg; takes commands from the command queue
`default_nettype none

module abs_back
  import abs_pkg::*;
#(
  parameter int MSG_BYTES  = 20,
  parameter int QUEUE_MSGS = 16,
  localparam int LW = $clog2(MSG_BYTES + 1),
  localparam int SW = (QUEUE_MSGS > 1) ? $clog2(QUEUE_MSGS) : 1,
  localparam int AW = (QUEUE_MSGS * MSG_BYTES > 1) ? $clog2(QUEUE_MSGS * MSG_BYTES) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_empty,
  input  wire abs_cmd_t            cmd,
  output logic                     cmd_pop,
  output logic                     busy,
  input  wire logic                qwr_en,
  input  wire logic [AW-1:0]       qwr_addr,
  input  wire logic [7:0]          qwr_data,
  input  wire logic                mwr_en,
  input  wire logic [SW-1:0]       mwr_slot,
  input  wire logic [LW-1:0]       mwr_len,
  input  wire logic [CHECK_W-1:0]  mwr_sum,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_seq,
  output logic [CHECK_W-1:0]       out_checksum,
  output logic [7:0]               out_byte,
  output logic                     out_last,
  output logic                     is_resend,
  output logic                     overflow_seen
);

  localparam int KW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

  // memories
  logic [7:0]         qmem [QUEUE_MSGS * MSG_BYTES];
  logic [LW-1:0]      meta_len [QUEUE_MSGS];
  logic [CHECK_W-1:0] meta_sum [QUEUE_MSGS];
  logic [7:0]         pmem [MSG_BYTES];
  logic [7:0]         q_rd_data;
  logic [7:0]         p_rd_data;
  logic [LW-1:0]      meta_len_rd;
  logic [CHECK_W-1:0] meta_sum_rd;

  // sequencer registers
  abs_bk_state_t      state, state_next;
  logic               cur_resend;
  logic               cur_seq;
  logic               cur_ovf;
  logic [AW-1:0]      cur_base;
  logic [SW-1:0]      head;
  logic [AW-1:0]      head_base;
  logic [KW-1:0]      k;
  logic [LW-1:0]      len;
  logic [CHECK_W-1:0] pend_check;

  // combinational controls
  logic               m_rd;
  logic               q_rd;
  logic               p_rd;
  logic               p_wr;
  logic               out_load;
  logic               out_free;
  logic               at_last;
  logic [7:0]         fresh_byte;
  logic [7:0]         byte_sel;

  assign busy       = (state != BK_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign at_last    = (k == KW'(MSG_BYTES - 1));
  assign fresh_byte = (LW'(k) < len) ? q_rd_data : 8'h00;
  assign byte_sel   = cur_resend ? p_rd_data : fresh_byte;

  // next state and strobes
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    m_rd       = 1'b0;
    q_rd       = 1'b0;
    p_rd       = 1'b0;
    p_wr       = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          m_rd       = !cmd.resend;
          state_next = cmd.resend ? BK_READ : BK_META;
        end
      end
      BK_META: begin
        state_next = BK_READ;
      end
      BK_READ: begin
        p_rd       = cur_resend;
        q_rd       = !cur_resend;
        state_next = BK_LOAD;
      end
      BK_LOAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          p_wr       = !cur_resend;
          state_next = at_last ? BK_IDLE : BK_READ;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      head      <= '0;
      head_base <= '0;
      k         <= '0;
    end else begin
      state <= state_next;
      if (cmd_pop) begin
        k <= '0;
        if (!cmd.resend) begin
          if (head == SW'(QUEUE_MSGS - 1)) begin
            head      <= '0;
            head_base <= '0;
          end else begin
            head      <= head + SW'(1);
            head_base <= head_base + AW'(MSG_BYTES);
          end
        end
      end else if (out_load && !at_last) begin
        k <= k + KW'(1);
      end
    end
  end

  // packet attributes
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_resend <= cmd.resend;
      cur_seq    <= cmd.seq;
      cur_ovf    <= cmd.ovf;
      cur_base   <= head_base;
    end
    if (state == BK_META) begin
      len        <= meta_len_rd;
      pend_check <= CHECK_W'(cur_seq) + meta_sum_rd;
    end
  end

  // message queue memory
  always_ff @(posedge clk) begin
    if (qwr_en) qmem[qwr_addr] <= qwr_data;
    if (q_rd) q_rd_data <= qmem[cur_base + AW'(k)];
  end

  // per-message length and byte sum
  always_ff @(posedge clk) begin
    if (mwr_en) begin
      meta_len[mwr_slot] <= mwr_len;
      meta_sum[mwr_slot] <= mwr_sum;
    end
    if (m_rd) begin
      meta_len_rd <= meta_len[head];
      meta_sum_rd <= meta_sum[head];
    end
  end

  // kept packet for retransmission
  always_ff @(posedge clk) begin
    if (p_wr) pmem[k] <= fresh_byte;
    if (p_rd) p_rd_data <= pmem[k];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_seq       <= cur_seq;
      out_checksum  <= pend_check;
      out_byte      <= byte_sel;
      out_last      <= at_last;
      is_resend     <= cur_resend;
      overflow_seen <= cur_ovf;
    end
  end

endmodule

`default_nettype wire

### rtl/core/alternating_bit_sender.sv
// alternating-bit sender top level: front end, command queue, back end
// depends on abs_pkg, abs_front, abs_cmd_fifo and abs_back
// first byte out after the command queue, META (fresh only), READ and LOAD; later if busy
// each byte needs a registered memory read (READ) before LOAD; a stalled output holds LOAD
// acks and ticks take 1 item per cycle unless the command queue is full; message bytes wait
// while a packet streams or is queued; reset: control state cleared, timeout 15, memories kept
`default_nettype none

module alternating_bit_sender
  import abs_pkg::*;
#(
  parameter int MSG_BYTES  = 20,
  parameter int QUEUE_MSGS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // data_byte[7:0], ack_seq_field[8], ack_number[9], ack_check_value[22:10], zero[23]
  input  wire logic [23:0] s_tdata,
  // kind[1:0]
  input  wire logic [1:0]  s_tuser,
  input  wire logic        s_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_seq[0], out_ack[1], out_checksum[14:2], out_byte[22:15], overflow_seen[23]
  output logic [23:0]      m_tdata,
  // is_resend[0]
  output logic             m_tuser,
  output logic             m_tlast
);

  localparam int LW = $clog2(MSG_BYTES + 1);
  localparam int SW = (QUEUE_MSGS > 1) ? $clog2(QUEUE_MSGS) : 1;
  localparam int AW = (QUEUE_MSGS * MSG_BYTES > 1) ? $clog2(QUEUE_MSGS * MSG_BYTES) : 1;

  abs_cmd_t           push_cmd;
  abs_cmd_t           head_cmd;
  logic               cmd_push;
  logic               cmd_pop;
  logic               cmd_full;
  logic               cmd_empty;
  logic               back_busy;
  logic               back_quiet;
  logic               qwr_en;
  logic [AW-1:0]      qwr_addr;
  logic [7:0]         qwr_data;
  logic               mwr_en;
  logic [SW-1:0]      mwr_slot;
  logic [LW-1:0]      mwr_len;
  logic [CHECK_W-1:0] mwr_sum;
  logic               o_seq;
  logic [CHECK_W-1:0] o_checksum;
  logic [7:0]         o_byte;
  logic               o_ovf;

  assign cfg_ready  = 1'b1;
  assign back_quiet = !back_busy && cmd_empty;

  // front end
  abs_front #(
    .MSG_BYTES  (MSG_BYTES),
    .QUEUE_MSGS (QUEUE_MSGS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .kind            (s_tuser),
    .data_byte       (s_tdata[7:0]),
    .byte_last       (s_tlast),
    .ack_seq_field   (s_tdata[8]),
    .ack_number      (s_tdata[9]),
    .ack_check_value (s_tdata[22:10]),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .cmd_push        (cmd_push),
    .cmd             (push_cmd),
    .cmd_full        (cmd_full),
    .back_quiet      (back_quiet),
    .qwr_en          (qwr_en),
    .qwr_addr        (qwr_addr),
    .qwr_data        (qwr_data),
    .mwr_en          (mwr_en),
    .mwr_slot        (mwr_slot),
    .mwr_len         (mwr_len),
    .mwr_sum         (mwr_sum)
  );

  // command queue
  abs_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (push_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .empty     (cmd_empty),
    .head_data (head_cmd)
  );

  // back end
  abs_back #(
    .MSG_BYTES  (MSG_BYTES),
    .QUEUE_MSGS (QUEUE_MSGS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_empty     (cmd_empty),
    .cmd           (head_cmd),
    .cmd_pop       (cmd_pop),
    .busy          (back_busy),
    .qwr_en        (qwr_en),
    .qwr_addr      (qwr_addr),
    .qwr_data      (qwr_data),
    .mwr_en        (mwr_en),
    .mwr_slot      (mwr_slot),
    .mwr_len       (mwr_len),
    .mwr_sum       (mwr_sum),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_seq       (o_seq),
    .out_checksum  (o_checksum),
    .out_byte      (o_byte),
    .out_last      (m_tlast),
    .is_resend     (m_tuser),
    .overflow_seen (o_ovf)
  );

  // output packing, ack field is always zero
  assign m_tdata = {o_ovf, o_byte, o_checksum, 1'b0, o_seq};

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for alternating_bit_sender: stream in, stream out, timeout register
// depends on abs_pkg and the alternating_bit_sender rtl; needs nothing else

module tb_top
  import abs_pkg::*;
();

  localparam int MSG_LEN = 20;
  localparam int QUEUE_DEPTH = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum {ACK_GOOD, ACK_WRONG_NUMBER, ACK_BAD_CHECK} ack_flavor_t;

  // one outgoing payload byte as the block should present it
  typedef struct packed {
    logic        seq;
    logic        ack;
    logic [12:0] chk;
    logic [7:0]  data;
    logic        last;
    logic        resend;
    logic        ovf;
  } out_beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  alternating_bit_sender #(
    .MSG_BYTES  (MSG_LEN),
    .QUEUE_MSGS (QUEUE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // data_byte, ack_seq_field, ack_number, ack_check_value, zero
    .s_tuser   (s_tuser),   // kind
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // out_seq, out_ack, out_checksum, out_byte, overflow_seen
    .m_tuser   (m_tuser),   // is_resend
    .m_tlast   (m_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender state mirrored in the testbench
  logic [15:0] timeout_reg = TIMEOUT_RESET;
  logic        sent_seq = 1'b0;
  logic        wait_ack = 1'b0;
  logic [7:0]  held_bytes [MSG_LEN];
  logic [12:0] held_sum = '0;
  logic [15:0] ticks_left = '0;
  logic [7:0]  msg_store [QUEUE_DEPTH][MSG_LEN];
  int          rd_slot = 0;
  int          wr_slot = 0;
  int          msg_count = 0;
  int          byte_pos = 0;
  logic [12:0] ack_running = '0;
  logic        ovf_sticky = 1'b0;
  logic        discard_msg = 1'b0;

  out_beat_t   due_bytes [$];
  out_beat_t   want;
  int          err_count = 0;
  int          useful_items = 0;
  int          burst_left = 6;
  int          ready_hold = 0;
  int          quiet_cycles = 0;

  function automatic logic [15:0] reload_ticks();
    return (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
  endfunction

  // queue all bytes of the held packet as expected output
  task automatic queue_packet(input logic resend);
    out_beat_t b;
    for (int k = 0; k < MSG_LEN; k++) begin
      b.seq    = sent_seq;
      b.ack    = 1'b0;
      b.chk    = held_sum;
      b.data   = held_bytes[k];
      b.last   = (k == MSG_LEN - 1);
      b.resend = resend;
      b.ovf    = ovf_sticky;
      due_bytes.push_back(b);
    end
  endtask

  // take the head message, checksum it and start waiting for its ack
  task automatic launch_next();
    logic [12:0] sum;
    if (msg_count == 0) return;
    sum = 13'(sent_seq);
    for (int k = 0; k < MSG_LEN; k++) begin
      held_bytes[k] = msg_store[rd_slot][k];
      sum = sum + 13'(held_bytes[k]);
    end
    held_sum   = sum;
    rd_slot    = (rd_slot + 1) % QUEUE_DEPTH;
    msg_count  = msg_count - 1;
    wait_ack   = 1'b1;
    ticks_left = reload_ticks();
    queue_packet(1'b0);
  endtask

  // advance the mirrored sender by one accepted input transaction
  task automatic sender_shadow_step(input logic [1:0] kind, input logic [7:0] data,
                                    input logic last, input logic seqf, input logic ackn,
                                    input logic [12:0] chk);
    logic [12:0] calc;
    case (kind)
      KIND_MSG: begin
        useful_items++;
        if (byte_pos == 0) begin
          discard_msg = (msg_count >= QUEUE_DEPTH);
          if (discard_msg) ovf_sticky = 1'b1;
        end
        if (!discard_msg && byte_pos < MSG_LEN) msg_store[wr_slot][byte_pos] = data;
        byte_pos++;
        if (last || byte_pos >= MSG_LEN) begin
          // short messages are zero padded
          if (!discard_msg) begin
            for (int k = byte_pos; k < MSG_LEN; k++) msg_store[wr_slot][k] = 8'd0;
            wr_slot   = (wr_slot + 1) % QUEUE_DEPTH;
            msg_count = msg_count + 1;
          end
          byte_pos    = 0;
          discard_msg = 1'b0;
          if (!wait_ack) launch_next();
        end
      end
      KIND_ACK: begin
        calc = ack_running + 13'(data);
        if (!last) begin
          useful_items++;
          ack_running = calc;
        end else begin
          ack_running = '0;
          calc = calc + 13'(seqf) + 13'(ackn);
          if (wait_ack && chk == calc && ackn == sent_seq) begin
            useful_items++;
            ticks_left = '0;
            sent_seq   = ~sent_seq;
            wait_ack   = 1'b0;
            launch_next();
          end
        end
      end
      KIND_TICK: begin
        if (wait_ack) begin
          useful_items++;
          if (ticks_left > 16'd1) begin
            ticks_left = ticks_left - 16'd1;
          end else begin
            ticks_left = reload_ticks();
            queue_packet(1'b1);
          end
        end
      end
      default: ;
    endcase
  endtask

  // drive one input transaction, wait for acceptance, then pace the burst
  task automatic push_item(input logic [1:0] kind, input logic [7:0] data, input logic last,
                           input logic seqf, input logic ackn, input logic [12:0] chk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, chk, ackn, seqf, data};
    s_tuser  <= kind;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sender_shadow_step(kind, data, last, seqf, ackn, chk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  // timeout register write, only once the block has drained
  task automatic write_timeout(input logic [15:0] value);
    if (s_tvalid) s_tvalid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timeout_reg = value;
  endtask

  task automatic send_message(input int len, input bit mark_last);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      push_item(KIND_MSG, b, mark_last && (i == len - 1), 1'($urandom), 1'($urandom),
                13'($urandom));
    end
  endtask

  // ack packet; header fields are only meaningful on the last byte
  task automatic send_ack(input int nbytes, input ack_flavor_t flavor, input bit heavy);
    logic [12:0] acc;
    logic [7:0]  b;
    logic        sf;
    logic        an;
    logic [12:0] chk;
    acc = '0;
    for (int i = 0; i < nbytes; i++) begin
      b   = heavy ? 8'($urandom_range(200, 255)) : 8'($urandom);
      acc = acc + 13'(b);
      if (i < nbytes - 1) begin
        push_item(KIND_ACK, b, 1'b0, 1'($urandom), 1'($urandom), 13'($urandom));
      end else begin
        sf  = 1'($urandom);
        an  = (flavor == ACK_WRONG_NUMBER) ? ~sent_seq : sent_seq;
        chk = acc + 13'(sf) + 13'(an);
        if (flavor == ACK_BAD_CHECK) chk = chk ^ 13'($urandom_range(1, 8191));
        push_item(KIND_ACK, b, 1'b1, sf, an, chk);
      end
    end
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++)
      push_item(KIND_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                13'($urandom));
  endtask

  // mostly well-formed exchanges with random content, some noise
  task automatic run_traffic(input int n_items);
    int start;
    int pick;
    int tmax;
    start = useful_items;
    while (useful_items - start < n_items) begin
      pick = $urandom_range(0, 99);
      tmax = (timeout_reg < 16'd6) ? int'(timeout_reg) + 1 : 6;
      if (wait_ack && pick < 40) begin
        if ($urandom_range(0, 19) == 0) send_ack($urandom_range(33, 40), ACK_GOOD, 1'b1);
        else send_ack($urandom_range(1, 4), ACK_GOOD, 1'b0);
      end else if (wait_ack && pick < 60) begin
        send_ticks($urandom_range(1, tmax));
      end else if (pick < 90) begin
        case ($urandom_range(0, 9))
          0, 1:    send_message(MSG_LEN, $urandom_range(0, 1));
          2:       send_message($urandom_range(MSG_LEN + 1, MSG_LEN + 4), 1'b0);
          3:       send_message($urandom_range(6, MSG_LEN - 1), 1'b1);
          default: send_message($urandom_range(1, 5), 1'b1);
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0: send_ack($urandom_range(1, 3), ACK_WRONG_NUMBER, 1'b0);
          1: send_ack($urandom_range(1, 3), ACK_BAD_CHECK, 1'b0);
          2: push_item(KIND_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       13'($urandom));
          default: send_ticks(1);
        endcase
      end
    end
  endtask

  // ticks, acks and unknown kinds with nothing outstanding
  task automatic test_idle_inputs();
    write_timeout(16'd3);
    push_item(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 13'h0000);
    push_item(KIND_ACK, 8'hFF, 1'b1, 1'b1, 1'b1, 13'h1FFF);
    push_item(KIND_UNUSED, 8'hAA, 1'b1, 1'b1, 1'b1, 13'h1555);
  endtask

  // padded short message, timeout resend, rejected and accepted acks
  task automatic test_first_packet();
    push_item(KIND_MSG, 8'hFF, 1'b0, 1'b1, 1'b1, 13'h1FFF);
    push_item(KIND_MSG, 8'h00, 1'b1, 1'b0, 1'b0, 13'h0000);
    send_ticks(3);
    // right checksum, wrong ack number
    push_item(KIND_ACK, 8'h00, 1'b1, 1'b1, 1'b1, 13'h0002);
    // bad checksum
    push_item(KIND_ACK, 8'h10, 1'b1, 1'b0, 1'b0, 13'h1FFF);
    // all-zero ack is valid for sequence bit 0
    push_item(KIND_ACK, 8'h00, 1'b1, 1'b0, 1'b0, 13'h0000);
  endtask

  // message running past its length without a last mark
  task automatic test_long_message();
    send_message(MSG_LEN + 1, 1'b0);
    send_message(1, 1'b1);
    send_ack(2, ACK_GOOD, 1'b0);
  endtask

  // traffic under a range of timeout settings, extremes included
  task automatic test_timeout_sweep();
    logic [15:0] settings [5];
    settings = '{16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(2, 9)), 16'($urandom_range(2, 9))};
    foreach (settings[i]) begin
      write_timeout(settings[i]);
      run_traffic(24);
    end
  endtask

  // fill the queue behind an unacked packet, drop messages, then drain
  task automatic test_queue_overflow();
    while (!wait_ack) send_message(1, 1'b1);
    while (msg_count < QUEUE_DEPTH) send_message($urandom_range(1, 3), 1'b1);
    send_message(3, 1'b1);
    send_message(1, 1'b1);
    while (wait_ack) send_ack($urandom_range(1, 3), ACK_GOOD, 1'b0);
  endtask

  // receiver: ready runs and stalls of random length, some long runs
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_hold <= 4;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_tready <= ~m_tready;
      if (m_tready) ready_hold <= $urandom_range(0, 9);
      else ready_hold <= ($urandom_range(0, 5) == 0) ? $urandom_range(60, 160)
                                                      : $urandom_range(0, 14);
    end
  end

  task automatic cmp_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      err_count++;
    end
  endtask

  // output checker: each output transaction against the oldest expected byte
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_bytes.size() == 0) begin
        $error("output transaction with nothing expected, tdata %h", m_tdata);
        err_count++;
      end else begin
        want = due_bytes.pop_front();
        cmp_field("out_seq", want.seq, m_tdata[0]);
        cmp_field("out_ack", want.ack, m_tdata[1]);
        cmp_field("out_checksum", want.chk, m_tdata[14:2]);
        cmp_field("out_byte", want.data, m_tdata[22:15]);
        cmp_field("overflow_seen", want.ovf, m_tdata[23]);
        cmp_field("is_resend", want.resend, m_tuser);
        cmp_field("out_last", want.last, m_tlast);
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_idle_inputs();
    test_first_packet();
    test_long_message();
    test_timeout_sweep();
    test_queue_overflow();
    run_traffic(20);
    if (s_tvalid) s_tvalid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && due_bytes.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
